// ----- rtl/uniform_grid_box_index_core_defines.svh -----
// ----------------------------------------------------------------------------
// Uniform grid box index - assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef UNIFORM_GRID_BOX_INDEX_CORE_DEFINES_SVH
`define UNIFORM_GRID_BOX_INDEX_CORE_DEFINES_SVH

// same-cycle implication
`define UGBI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ugbi: same-cycle check failed");

// next-cycle implication
`define UGBI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ugbi: next-cycle check failed");

`endif

// ----- rtl/ugbi_pkg.sv -----
// ----------------------------------------------------------------------------
// ugbi_pkg
// Types and fixed constants of the uniform grid box index.
// ----------------------------------------------------------------------------
package ugbi_pkg;

  localparam int COORD_W   = 24;  // signed coordinate / size
  localparam int EXT_W     = 23;  // unsigned register extents, half extents
  localparam int SUM_W     = 27;  // signed doubled-coordinate sums
  localparam int DIVD_W    = 26;  // non-negative dividend
  localparam int DIVS_W    = 24;  // divisor (cell size, or twice it)
  localparam int RES_IDX_W = 6;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WORLD_W = 2'd0,
    CFG_WORLD_H = 2'd1,
    CFG_CELL    = 2'd2
  } cfg_idx_e;

  // one division job per grid quantity
  typedef enum logic [2:0] {
    JOB_DIM_X,
    JOB_DIM_Y,
    JOB_INS_COL,
    JOB_INS_ROW,
    JOB_Q_COL_LO,
    JOB_Q_COL_HI,
    JOB_Q_ROW_LO,
    JOB_Q_ROW_HI
  } job_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV_GO,
    S_DIV_WAIT,
    S_COMMIT,
    S_SCAN_INIT,
    S_SCAN
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic early_emit;
    logic div_start;
    logic capture;
    logic commit;
    logic scan_start;
    logic scan_step;
    logic scan_finish;
    job_e job;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    cmd_e cmd;
    logic early_hit;
    logic div_done;
    logic scan_done;
  } sts_t;

endpackage

// ----- rtl/ugbi_div.sv -----
// ----------------------------------------------------------------------------
// ugbi_div
// Restoring divider, one quotient bit per cycle, quotient saturated at QB bits.
// ----------------------------------------------------------------------------
module ugbi_div #(
  parameter int QB = 9,
  parameter int DW = 26,
  parameter int VW = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          busy_o,
  output logic          done_o,
  output logic [QB-1:0] quot_o
);

  localparam int RW    = (DW > VW + QB) ? DW : VW + QB;
  localparam int CNT_W = $clog2(QB + 1);

  logic [RW-1:0]    rem_q, rem_d, dsh_q, dsh_d;
  logic [QB-1:0]    quo_q, quo_d;
  logic [CNT_W-1:0] cnt_q;
  logic             run_q, done_q, sat_q;
  logic             ovf, ge;

  // quotient would not fit in QB bits
  assign ovf = RW'(dividend_i) >= (RW'(divisor_i) << QB);

  // one restoring step
  assign ge    = rem_q >= dsh_q;
  assign rem_d = ge ? rem_q - dsh_q : rem_q;
  assign dsh_d = dsh_q >> 1;
  assign quo_d = (quo_q << 1) | QB'(ge);

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CNT_W'(QB);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operands
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= RW'(dividend_i);
      dsh_q <= RW'(divisor_i) << (QB - 1);
      quo_q <= '0;
      sat_q <= ovf;
    end else if (run_q) begin
      rem_q <= rem_d;
      dsh_q <= dsh_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o = run_q;
  assign done_o = done_q;
  assign quot_o = sat_q ? '1 : quo_q;

endmodule

// ----- rtl/ugbi_dp.sv -----
// ----------------------------------------------------------------------------
// ugbi_dp
// Datapath: registers, grid state, box cell memory, divider and scan logic.
// ----------------------------------------------------------------------------
`include "uniform_grid_box_index_core_defines.svh"

module ugbi_dp #(
  parameter int MAX_BOXES    = 64,
  parameter int MAX_GRID_DIM = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ugbi_pkg::ctl_t                       ctl_i,
  output ugbi_pkg::sts_t                       sts_o,
  input  logic                                 cfg_valid_i,
  input  logic [ugbi_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [ugbi_pkg::EXT_W-1:0]           cfg_data_i,
  input  logic [1:0]                           cmd_i,
  input  logic signed [ugbi_pkg::COORD_W-1:0]  pos_x_i,
  input  logic signed [ugbi_pkg::COORD_W-1:0]  pos_y_i,
  input  logic signed [ugbi_pkg::COORD_W-1:0]  size_x_i,
  input  logic signed [ugbi_pkg::COORD_W-1:0]  size_y_i,
  output logic                                 result_valid_o,
  output logic [1:0]                           status_o,
  output logic                                 found_o,
  output logic [ugbi_pkg::RES_IDX_W-1:0]       box_index_o,
  output logic                                 last_o
);

  localparam int CW     = $clog2(MAX_GRID_DIM + 1);
  localparam int CELL_W = (MAX_GRID_DIM > 1) ? $clog2(MAX_GRID_DIM) : 1;
  localparam int QB     = $clog2(MAX_GRID_DIM) + 1;
  localparam int BCW    = $clog2(MAX_BOXES + 1);
  localparam int IW     = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int SW     = ugbi_pkg::SUM_W;
  localparam int EW     = ugbi_pkg::EXT_W;
  localparam int CRW    = ugbi_pkg::COORD_W;

  // configuration registers
  logic [EW-1:0] ww_q, wh_q, cell_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ww_q   <= EW'(25600);
      wh_q   <= EW'(25600);
      cell_q <= EW'(2048);
    end else if (cfg_valid_i) begin
      case (ugbi_pkg::cfg_idx_e'(cfg_index_i))
        ugbi_pkg::CFG_WORLD_W: ww_q   <= cfg_data_i;
        ugbi_pkg::CFG_WORLD_H: wh_q   <= cfg_data_i;
        ugbi_pkg::CFG_CELL:    cell_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // latched item
  ugbi_pkg::cmd_e        cmd_q;
  logic signed [CRW-1:0] px_q, py_q, sx_q, sy_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q <= ugbi_pkg::cmd_e'(cmd_i);
      px_q  <= pos_x_i;
      py_q  <= pos_y_i;
      sx_q  <= size_x_i;
      sy_q  <= size_y_i;
    end
  end

  // grid state
  logic [BCW-1:0] bc_q;
  logic [EW-1:0]  hx_q, hy_q;
  logic [CW-1:0]  col_q, row_q;
  logic           failed_q;
  logic [CW-1:0]  lo_x_q, hi_x_q, lo_y_q, hi_y_q;

  // immediate single-result outcomes
  logic               early_hit, early_fail;
  ugbi_pkg::status_e  early_st;
  logic               sx_nonpos, sy_nonpos;

  assign sx_nonpos = sx_q[CRW-1] || (sx_q == '0);
  assign sy_nonpos = sy_q[CRW-1] || (sy_q == '0);

  always_comb begin
    early_hit  = 1'b0;
    early_fail = 1'b0;
    early_st   = ugbi_pkg::ST_REJECT;
    case (cmd_q)
      ugbi_pkg::CMD_CLEAR: begin
        if (cell_q == '0 || ww_q == '0 || wh_q == '0) begin
          early_hit  = 1'b1;
          early_fail = 1'b1;
        end
      end
      ugbi_pkg::CMD_INSERT: begin
        if (failed_q) begin
          early_hit = 1'b1;
        end else if (sx_nonpos || sy_nonpos) begin
          early_hit  = 1'b1;
          early_fail = 1'b1;
        end else if (bc_q >= BCW'(MAX_BOXES)) begin
          early_hit = 1'b1;
          early_st  = ugbi_pkg::ST_FULL;
        end
      end
      ugbi_pkg::CMD_QUERY: begin
        if (failed_q || sx_q[CRW-1] || sy_q[CRW-1]) begin
          early_hit = 1'b1;
        end
      end
      default: early_hit = 1'b1;
    endcase
  end

  // divider operands per job
  logic signed [SW-1:0] px2, py2, sx1, sy1, sx2, sy2, hxs, hys, sum;
  logic [CRW-1:0]              dim_sum;
  logic                        is_dim, is_col, force0;
  logic [ugbi_pkg::DIVD_W-1:0] dvd;
  logic [ugbi_pkg::DIVS_W-1:0] dvs;

  assign px2 = {{(SW-CRW-1){px_q[CRW-1]}}, px_q, 1'b0};
  assign py2 = {{(SW-CRW-1){py_q[CRW-1]}}, py_q, 1'b0};
  assign sx2 = {{(SW-CRW-1){sx_q[CRW-1]}}, sx_q, 1'b0};
  assign sy2 = {{(SW-CRW-1){sy_q[CRW-1]}}, sy_q, 1'b0};
  assign sx1 = {{(SW-CRW){sx_q[CRW-1]}}, sx_q};
  assign sy1 = {{(SW-CRW){sy_q[CRW-1]}}, sy_q};
  assign hxs = {{(SW-EW){1'b0}}, hx_q};
  assign hys = {{(SW-EW){1'b0}}, hy_q};

  always_comb begin
    is_dim  = 1'b0;
    is_col  = 1'b0;
    sum     = '0;
    dim_sum = {1'b0, ww_q} + {1'b0, cell_q} - CRW'(1);
    case (ctl_i.job)
      ugbi_pkg::JOB_DIM_X: is_dim = 1'b1;
      ugbi_pkg::JOB_DIM_Y: begin
        is_dim  = 1'b1;
        dim_sum = {1'b0, wh_q} + {1'b0, cell_q} - CRW'(1);
      end
      ugbi_pkg::JOB_INS_COL: begin
        is_col = 1'b1;
        sum    = px2 + sx1;
      end
      ugbi_pkg::JOB_INS_ROW:  sum = py2 + sy1;
      ugbi_pkg::JOB_Q_COL_LO: begin
        is_col = 1'b1;
        sum    = px2 - hxs;
      end
      ugbi_pkg::JOB_Q_COL_HI: begin
        is_col = 1'b1;
        sum    = px2 + sx2 + hxs;
      end
      ugbi_pkg::JOB_Q_ROW_LO: sum = py2 - hys;
      ugbi_pkg::JOB_Q_ROW_HI: sum = py2 + sy2 + hys;
      default: ;
    endcase
  end

  assign dvd    = is_dim ? {{(ugbi_pkg::DIVD_W-CRW){1'b0}}, dim_sum}
                         : sum[ugbi_pkg::DIVD_W-1:0];
  assign dvs    = is_dim ? {1'b0, cell_q} : {cell_q, 1'b0};
  assign force0 = !is_dim && (sum[SW-1] || cell_q == '0);

  // divider
  logic          div_busy, div_done;
  logic [QB-1:0] quot;

  ugbi_div #(
    .QB (QB),
    .DW (ugbi_pkg::DIVD_W),
    .VW (ugbi_pkg::DIVS_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctl_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // clamp quotient into grid count or cell range
  logic [CW-1:0] lim, cap_val;

  assign lim = (is_col ? col_q : row_q) - CW'(1);

  always_comb begin
    if (is_dim) begin
      if (quot == '0) cap_val = CW'(1);
      else if (quot > QB'(MAX_GRID_DIM)) cap_val = CW'(MAX_GRID_DIM);
      else cap_val = quot[CW-1:0];
    end else if (force0) begin
      cap_val = '0;
    end else if (quot > QB'(lim)) begin
      cap_val = lim;
    end else begin
      cap_val = quot[CW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      case (ctl_i.job)
        ugbi_pkg::JOB_DIM_X, ugbi_pkg::JOB_INS_COL,
        ugbi_pkg::JOB_Q_COL_LO: lo_x_q <= cap_val;
        ugbi_pkg::JOB_Q_COL_HI: hi_x_q <= cap_val;
        ugbi_pkg::JOB_DIM_Y, ugbi_pkg::JOB_INS_ROW,
        ugbi_pkg::JOB_Q_ROW_LO: lo_y_q <= cap_val;
        ugbi_pkg::JOB_Q_ROW_HI: hi_y_q <= cap_val;
        default: ;
      endcase
    end
  end

  // grid state update
  logic ins_commit;
  assign ins_commit = ctl_i.commit && cmd_q == ugbi_pkg::CMD_INSERT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q     <= '0;
      hx_q     <= '0;
      hy_q     <= '0;
      col_q    <= CW'(1);
      row_q    <= CW'(1);
      failed_q <= 1'b0;
    end else if (ctl_i.early_emit && early_fail) begin
      failed_q <= 1'b1;
      if (cmd_q == ugbi_pkg::CMD_CLEAR) begin
        bc_q  <= '0;
        hx_q  <= '0;
        hy_q  <= '0;
        col_q <= CW'(1);
        row_q <= CW'(1);
      end
    end else if (ctl_i.commit) begin
      if (cmd_q == ugbi_pkg::CMD_CLEAR) begin
        bc_q     <= '0;
        hx_q     <= '0;
        hy_q     <= '0;
        col_q    <= lo_x_q;
        row_q    <= lo_y_q;
        failed_q <= 1'b0;
      end else begin
        bc_q <= bc_q + 1'b1;
        if (sx_q[EW-1:0] > hx_q) hx_q <= sx_q[EW-1:0];
        if (sy_q[EW-1:0] > hy_q) hy_q <= sy_q[EW-1:0];
      end
    end
  end

  // box cell memory: {row, column}
  logic [2*CELL_W-1:0] mem_q [MAX_BOXES];
  logic [2*CELL_W-1:0] rd_q;
  logic [BCW-1:0]      scan_q;
  logic                scan_live;

  assign scan_live = ctl_i.scan_step && (scan_q < bc_q);

  always_ff @(posedge clk_i) begin
    if (ins_commit) begin
      mem_q[bc_q[IW-1:0]] <= {lo_y_q[CELL_W-1:0], lo_x_q[CELL_W-1:0]};
    end
    if (scan_live) begin
      rd_q <= mem_q[scan_q[IW-1:0]];
    end
  end

  // scan with one pending match, so the final match carries last
  logic          rd_vld_q, pend_vld_q;
  logic [IW-1:0] rd_idx_q, pend_idx_q;
  logic [CW-1:0] rc, rr;
  logic          match;

  assign rc    = CW'(rd_q[CELL_W-1:0]);
  assign rr    = CW'(rd_q[2*CELL_W-1:CELL_W]);
  assign match = rd_vld_q && rc >= lo_x_q && rc <= hi_x_q && rr >= lo_y_q && rr <= hi_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q     <= '0;
      rd_vld_q   <= 1'b0;
      pend_vld_q <= 1'b0;
    end else if (ctl_i.scan_start) begin
      scan_q     <= '0;
      rd_vld_q   <= 1'b0;
      pend_vld_q <= 1'b0;
    end else if (ctl_i.scan_step) begin
      rd_vld_q <= scan_live;
      if (scan_live) scan_q <= scan_q + 1'b1;
      if (match) pend_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_live) rd_idx_q <= scan_q[IW-1:0];
    if (ctl_i.scan_step && match) pend_idx_q <= rd_idx_q;
  end

  // result register
  logic                      rv_q, rv_d, found_q, found_d, last_q, last_d;
  ugbi_pkg::status_e         st_q, st_d;
  logic [IW-1:0]             idx_q, idx_d;

  always_comb begin
    rv_d    = 1'b0;
    st_d    = ugbi_pkg::ST_OK;
    found_d = 1'b0;
    idx_d   = '0;
    last_d  = 1'b1;
    if (ctl_i.early_emit) begin
      rv_d = 1'b1;
      st_d = early_st;
    end else if (ctl_i.commit) begin
      rv_d = 1'b1;
    end else if (ctl_i.scan_step && match && pend_vld_q) begin
      rv_d    = 1'b1;
      found_d = 1'b1;
      idx_d   = pend_idx_q;
      last_d  = 1'b0;
    end else if (ctl_i.scan_finish) begin
      rv_d    = 1'b1;
      found_d = pend_vld_q;
      idx_d   = pend_vld_q ? pend_idx_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rv_q <= 1'b0;
    else rv_q <= rv_d;
  end

  always_ff @(posedge clk_i) begin
    st_q    <= st_d;
    found_q <= found_d;
    idx_q   <= idx_d;
    last_q  <= last_d;
  end

  assign result_valid_o = rv_q;
  assign status_o       = st_q;
  assign found_o        = found_q;
  assign box_index_o    = ugbi_pkg::RES_IDX_W'(idx_q);
  assign last_o         = last_q;

  assign sts_o.cmd       = cmd_q;
  assign sts_o.early_hit = early_hit;
  assign sts_o.div_done  = div_done;
  assign sts_o.scan_done = (scan_q >= bc_q) && !rd_vld_q;

  // checks
  `UGBI_ASSERT_IMP(a_one_source, 1'b1,
    $onehot0({ctl_i.early_emit, ctl_i.commit, ctl_i.scan_finish, ctl_i.div_start}))
  `UGBI_ASSERT_IMP(a_div_free, ctl_i.div_start, !div_busy)
  `UGBI_ASSERT_IMP(a_count_bound, 1'b1, bc_q <= BCW'(MAX_BOXES))
  `UGBI_ASSERT_NEXT(a_clear_resets, ctl_i.commit && cmd_q == ugbi_pkg::CMD_CLEAR,
    !failed_q && bc_q == '0)

endmodule

// ----- rtl/ugbi_ctrl.sv -----
// ----------------------------------------------------------------------------
// ugbi_ctrl
// Command sequencer: checks, division jobs, commit and match scan.
// ----------------------------------------------------------------------------
module ugbi_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  ugbi_pkg::sts_t sts_i,
  output ugbi_pkg::ctl_t ctl_o
);

  ugbi_pkg::state_e state_q, state_d;
  ugbi_pkg::job_e   job_q, job_d;
  logic             last_job;
  ugbi_pkg::job_e   next_job, first_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ugbi_pkg::S_IDLE;
      job_q   <= ugbi_pkg::JOB_DIM_X;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
    end
  end

  // job ordering
  always_comb begin
    last_job = 1'b0;
    next_job = job_q;
    case (job_q)
      ugbi_pkg::JOB_DIM_X:    next_job = ugbi_pkg::JOB_DIM_Y;
      ugbi_pkg::JOB_INS_COL:  next_job = ugbi_pkg::JOB_INS_ROW;
      ugbi_pkg::JOB_Q_COL_LO: next_job = ugbi_pkg::JOB_Q_COL_HI;
      ugbi_pkg::JOB_Q_COL_HI: next_job = ugbi_pkg::JOB_Q_ROW_LO;
      ugbi_pkg::JOB_Q_ROW_LO: next_job = ugbi_pkg::JOB_Q_ROW_HI;
      default:                last_job = 1'b1;
    endcase
    case (sts_i.cmd)
      ugbi_pkg::CMD_CLEAR:  first_job = ugbi_pkg::JOB_DIM_X;
      ugbi_pkg::CMD_INSERT: first_job = ugbi_pkg::JOB_INS_COL;
      default:              first_job = ugbi_pkg::JOB_Q_COL_LO;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    case (state_q)
      ugbi_pkg::S_IDLE: begin
        if (start_i) state_d = ugbi_pkg::S_CHECK;
      end
      ugbi_pkg::S_CHECK: begin
        if (sts_i.early_hit) begin
          state_d = ugbi_pkg::S_IDLE;
        end else begin
          job_d   = first_job;
          state_d = ugbi_pkg::S_DIV_GO;
        end
      end
      ugbi_pkg::S_DIV_GO: state_d = ugbi_pkg::S_DIV_WAIT;
      ugbi_pkg::S_DIV_WAIT: begin
        if (sts_i.div_done) begin
          if (!last_job) begin
            job_d   = next_job;
            state_d = ugbi_pkg::S_DIV_GO;
          end else if (sts_i.cmd == ugbi_pkg::CMD_QUERY) begin
            state_d = ugbi_pkg::S_SCAN_INIT;
          end else begin
            state_d = ugbi_pkg::S_COMMIT;
          end
        end
      end
      ugbi_pkg::S_COMMIT:    state_d = ugbi_pkg::S_IDLE;
      ugbi_pkg::S_SCAN_INIT: state_d = ugbi_pkg::S_SCAN;
      ugbi_pkg::S_SCAN: begin
        if (sts_i.scan_done) state_d = ugbi_pkg::S_IDLE;
      end
      default: state_d = ugbi_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl_o     = '0;
    ctl_o.job = job_q;
    case (state_q)
      ugbi_pkg::S_IDLE:      ctl_o.load = start_i;
      ugbi_pkg::S_CHECK:     ctl_o.early_emit = sts_i.early_hit;
      ugbi_pkg::S_DIV_GO:    ctl_o.div_start = 1'b1;
      ugbi_pkg::S_DIV_WAIT:  ctl_o.capture = sts_i.div_done;
      ugbi_pkg::S_COMMIT:    ctl_o.commit = 1'b1;
      ugbi_pkg::S_SCAN_INIT: ctl_o.scan_start = 1'b1;
      ugbi_pkg::S_SCAN: begin
        ctl_o.scan_step   = !sts_i.scan_done;
        ctl_o.scan_finish = sts_i.scan_done;
      end
      default: ;
    endcase
  end

  assign busy_o = state_q != ugbi_pkg::S_IDLE;

endmodule

// ----- rtl/uniform_grid_box_index_core.sv -----
// ----------------------------------------------------------------------------
// uniform_grid_box_index_core
// Uniform grid index of boxes: clear/build, insert by center cell, range query.
// ----------------------------------------------------------------------------
// Issue a command with start_i while busy_o is low. Every result shows for one
// cycle with result_valid_o and cannot be held off; last_o marks the final one.
// One command at a time. Each grid division is a bit-serial divider run. A
// clear takes two divisions, an insert two, a query four followed by a
// memory scan over the stored boxes. Rejected commands finish without any
// division. Configuration writes are always ready; the registers are read
// live during a command, so write them only while idle.
module uniform_grid_box_index_core #(
  parameter int MAX_BOXES    = 64,
  parameter int MAX_GRID_DIM = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic [1:0]                           cmd_i,
  input  logic signed [ugbi_pkg::COORD_W-1:0]  pos_x_i,
  input  logic signed [ugbi_pkg::COORD_W-1:0]  pos_y_i,
  input  logic signed [ugbi_pkg::COORD_W-1:0]  size_x_i,
  input  logic signed [ugbi_pkg::COORD_W-1:0]  size_y_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ugbi_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [ugbi_pkg::EXT_W-1:0]           cfg_data_i,
  output logic                                 result_valid_o,
  output logic [1:0]                           status_o,
  output logic                                 found_o,
  output logic [ugbi_pkg::RES_IDX_W-1:0]       box_index_o,
  output logic                                 last_o
);

  ugbi_pkg::ctl_t ctl;
  ugbi_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  ugbi_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .sts_i  (sts),
    .ctl_o  (ctl)
  );

  ugbi_dp #(
    .MAX_BOXES    (MAX_BOXES),
    .MAX_GRID_DIM (MAX_GRID_DIM)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .size_x_i       (size_x_i),
    .size_y_i       (size_y_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .found_o        (found_o),
    .box_index_o    (box_index_o),
    .last_o         (last_o)
  );

endmodule
